### rtl/tte_pkg.sv
`timescale 1ns / 1ps
// Shared codes and types of the tiled texel encoder.
package tte_pkg;

    // texture format codes
    localparam logic [3:0] FMT_I4     = 4'd0;
    localparam logic [3:0] FMT_I8     = 4'd1;
    localparam logic [3:0] FMT_IA4    = 4'd2;
    localparam logic [3:0] FMT_IA8    = 4'd3;
    localparam logic [3:0] FMT_RGB565 = 4'd4;
    localparam logic [3:0] FMT_RGB5A3 = 4'd5;
    localparam logic [3:0] FMT_RGBA8  = 4'd6;
    localparam logic [3:0] FMT_CI4    = 4'd7;
    localparam logic [3:0] FMT_CI8    = 4'd8;

    // configuration register indexes
    localparam logic [1:0] CFG_FORMAT      = 2'd0;
    localparam logic [1:0] CFG_IMAGE_WIDTH = 2'd1;
    localparam logic [1:0] CFG_ALPHA_IMG   = 2'd2;
    localparam logic [1:0] CFG_BASE_OFFSET = 2'd3;

    // write size codes
    localparam logic [1:0] SZ_NIBBLE   = 2'd0;
    localparam logic [1:0] SZ_BYTE     = 2'd1;
    localparam logic [1:0] SZ_HALFWORD = 2'd2;

    localparam int ADDR_W = 24;
    localparam int DATA_W = 16;
    localparam int CFG_W  = 24;

    // tile geometry class
    typedef enum logic [1:0] {
        CLS_8X8,
        CLS_8X4,
        CLS_4X4
    } t_tile_cls;

endpackage

### rtl/tiled_texel_encoder.sv
`timescale 1ns / 1ps
// Tiled texel encoder: pixel in, encoded texel and tiled byte address out.
//
//  channel  | valid        | ready         | payload
//  ---------+--------------+---------------+-----------------------------------------
//  pixel in | i_valid      | o_ready       | i_pixel_x/y, i_red..i_alpha, i_palette_index
//  texel out| o_valid      | i_ready       | o_byte_address, o_write_data, o_write_size,
//           |              |               | o_high_nibble, o_last_write
//  config   | i_cfg_valid  | o_cfg_ready   | i_cfg_index, i_cfg_data
//
// Four register stages: input, tile coordinates, tile-row product and intensity,
// output. One pixel per cycle while the output is not stalled; RGBA8 pixels hold the
// output register for a second write to give the GB halfword.
// Synchronous active-low reset clears the valid bits and resets the config registers.
// Each stage holds while the next one is full and stalled; nothing is lost or repeated.
module tiled_texel_encoder #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [tte_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [9:0]                   i_pixel_x,
    input  logic [9:0]                   i_pixel_y,
    input  logic [7:0]                   i_red,
    input  logic [7:0]                   i_green,
    input  logic [7:0]                   i_blue,
    input  logic [7:0]                   i_alpha,
    input  logic [7:0]                   i_palette_index,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [tte_pkg::ADDR_W-1:0]   o_byte_address,
    output logic [tte_pkg::DATA_W-1:0]   o_write_data,
    output logic [1:0]                   o_write_size,
    output logic                         o_high_nibble,
    output logic                         o_last_write
);
    import tte_pkg::*;

    localparam int XLIM  = (MAX_WIDTH - 1 > 1023) ? 1023 : MAX_WIDTH - 1;
    localparam int YLIM  = (MAX_HEIGHT - 1 > 1023) ? 1023 : MAX_HEIGHT - 1;
    localparam int WCAP  = (MAX_WIDTH > 2047) ? 2047 : MAX_WIDTH;
    localparam logic [9:0]  XLIM_V = XLIM[9:0];
    localparam logic [9:0]  YLIM_V = YLIM[9:0];
    localparam logic [10:0] WCAP_V = WCAP[10:0];
    localparam int TRW   = $clog2(MAX_WIDTH / 4 + 2);   // tiles per row
    localparam int PRW   = TRW + 8;                     // tile-row product
    localparam int TLW   = PRW + 1;                     // tile number
    localparam logic [9:0] RECIP3 = 10'd683;            // 2^11 / 3, rounded up

    // configuration registers
    logic [3:0]        r_format;
    logic [10:0]       r_image_width;
    logic              r_alpha_img;
    logic [ADDR_W-1:0] r_base_offset;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format      <= FMT_I4;
            r_image_width <= 11'd8;
            r_alpha_img   <= 1'b0;
            r_base_offset <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FORMAT:      r_format      <= i_cfg_data[3:0];
                CFG_IMAGE_WIDTH: r_image_width <= i_cfg_data[10:0];
                CFG_ALPHA_IMG:   r_alpha_img   <= i_cfg_data[0];
                CFG_BASE_OFFSET: r_base_offset <= i_cfg_data[ADDR_W-1:0];
            endcase
        end
    end

    // decoded geometry; user keeps it static while items are in flight, unenforced
    t_tile_cls        cls;
    logic [10:0]      width_sat;
    logic [11:0]      width_pad;
    logic [TRW-1:0]   tiles_row;
    logic             fmt_ok;

    always_comb begin
        case (r_format) inside
            FMT_I4, FMT_CI4:          cls = CLS_8X8;
            FMT_I8, FMT_IA4, FMT_CI8: cls = CLS_8X4;
            default:                  cls = CLS_4X4;
        endcase
        width_sat = (r_image_width > WCAP_V) ? WCAP_V : r_image_width;
        if (cls == CLS_4X4) begin
            width_pad = ({1'b0, width_sat} + 12'd3) >> 2;
        end else begin
            width_pad = ({1'b0, width_sat} + 12'd7) >> 3;
        end
        tiles_row = TRW'(width_pad);
        fmt_ok    = (r_format <= FMT_CI8);
    end

    // pipeline valid bits and stage enables
    logic r1_v, r2_v, r3_v, r_ov, r_pend;
    logic en1, en2, en3, en_o;

    assign en_o    = !r_ov || (i_ready && !r_pend);
    assign en3     = !r3_v || en_o;
    assign en2     = !r2_v || en3;
    assign en1     = !r1_v || en2;
    assign o_ready = en1;

    // stage 1: input register
    logic [9:0] r1_x, r1_y;
    logic [7:0] r1_r, r1_g, r1_b, r1_a, r1_ci;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_x  <= i_pixel_x;
            r1_y  <= i_pixel_y;
            r1_r  <= i_red;
            r1_g  <= i_green;
            r1_b  <= i_blue;
            r1_a  <= i_alpha;
            r1_ci <= i_palette_index;
        end
    end

    // stage 2: tile coordinates, texel index in tile, component sum
    logic [9:0] xc, yc;
    logic [7:0] n2_tx, n2_ty;
    logic [5:0] n2_p;
    logic [9:0] n2_sum;

    always_comb begin
        xc = (r1_x > XLIM_V) ? XLIM_V : r1_x;
        yc = (r1_y > YLIM_V) ? YLIM_V : r1_y;
        unique case (cls)
            CLS_8X8: begin
                n2_tx = {1'b0, xc[9:3]};
                n2_ty = {1'b0, yc[9:3]};
                n2_p  = {yc[2:0], xc[2:0]};
            end
            CLS_8X4: begin
                n2_tx = {1'b0, xc[9:3]};
                n2_ty = yc[9:2];
                n2_p  = {1'b0, yc[1:0], xc[2:0]};
            end
            default: begin
                n2_tx = xc[9:2];
                n2_ty = yc[9:2];
                n2_p  = {2'b00, yc[1:0], xc[1:0]};
            end
        endcase
        n2_sum = {2'b00, r1_r} + {2'b00, r1_g} + {2'b00, r1_b};
    end

    logic [7:0]     r2_tx, r2_ty;
    logic [5:0]     r2_p;
    logic [9:0]     r2_sum;
    logic           r2_x0;
    logic [TRW-1:0] r2_trow;
    logic [7:0]     r2_r, r2_g, r2_b, r2_a, r2_ci;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_tx   <= n2_tx;
            r2_ty   <= n2_ty;
            r2_p    <= n2_p;
            r2_sum  <= n2_sum;
            r2_x0   <= xc[0];
            r2_trow <= tiles_row;
            r2_r    <= r1_r;
            r2_g    <= r1_g;
            r2_b    <= r1_b;
            r2_a    <= r1_a;
            r2_ci   <= r1_ci;
        end
    end

    // stage 3: tile-row product and intensity by reciprocal multiply
    logic [PRW-1:0] n3_prod;
    logic [19:0]    n3_isum;

    assign n3_prod = PRW'(r2_ty * r2_trow);
    assign n3_isum = r2_sum * RECIP3;

    logic [PRW-1:0] r3_prod;
    logic [7:0]     r3_inten, r3_tx;
    logic [5:0]     r3_p;
    logic           r3_x0;
    logic [7:0]     r3_r, r3_g, r3_b, r3_a, r3_ci;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_prod  <= n3_prod;
            r3_inten <= n3_isum[18:11];
            r3_tx    <= r2_tx;
            r3_p     <= r2_p;
            r3_x0    <= r2_x0;
            r3_r     <= r2_r;
            r3_g     <= r2_g;
            r3_b     <= r2_b;
            r3_a     <= r2_a;
            r3_ci    <= r2_ci;
        end
    end

    // output stage: address and texel encoding
    logic [TLW-1:0]    tile;
    logic [ADDR_W-1:0] tile_bytes, base;
    logic [6:0]        offs;
    logic [ADDR_W-1:0] n_addr;
    logic [DATA_W-1:0] n_data;
    logic [1:0]        n_size;
    logic              n_hi;
    logic [7:0]        al_ia4, al_ia8;

    always_comb begin
        tile = {1'b0, r3_prod} + TLW'(r3_tx);
        if (r_format == FMT_RGBA8) begin
            tile_bytes = ADDR_W'(tile) << 6;
        end else begin
            tile_bytes = ADDR_W'(tile) << 5;
        end
        base   = r_base_offset + tile_bytes;
        al_ia4 = r_alpha_img ? r3_a : 8'hF0;
        al_ia8 = r_alpha_img ? r3_a : 8'hFF;
        n_hi   = 1'b0;
        case (r_format)
            FMT_I4: begin
                n_data = {12'd0, r3_inten[7:4]};
                n_size = SZ_NIBBLE;
                n_hi   = !r3_x0;
            end
            FMT_I8: begin
                n_data = {8'd0, r3_inten};
                n_size = SZ_BYTE;
            end
            FMT_IA4: begin
                n_data = {8'd0, al_ia4[7:4], r3_inten[7:4]};
                n_size = SZ_BYTE;
            end
            FMT_IA8: begin
                n_data = {al_ia8, r3_inten};
                n_size = SZ_HALFWORD;
            end
            FMT_RGB565: begin
                n_data = {r3_r[7:3], r3_g[7:2], r3_b[7:3]};
                n_size = SZ_HALFWORD;
            end
            FMT_RGB5A3: begin
                if (r3_a >= 8'd224) begin
                    n_data = {1'b1, r3_r[7:3], r3_g[7:3], r3_b[7:3]};
                end else begin
                    n_data = {1'b0, r3_a[7:5], r3_r[7:4], r3_g[7:4], r3_b[7:4]};
                end
                n_size = SZ_HALFWORD;
            end
            FMT_RGBA8: begin
                n_data = {r3_a, r3_r};
                n_size = SZ_HALFWORD;
            end
            FMT_CI4: begin
                n_data = {12'd0, r3_ci[3:0]};
                n_size = SZ_NIBBLE;
                n_hi   = !r3_x0;
            end
            default: begin
                n_data = {8'd0, r3_ci};
                n_size = SZ_BYTE;
            end
        endcase
        case (n_size)
            SZ_NIBBLE: offs = {2'b00, r3_p[5:1]};
            SZ_BYTE:   offs = {1'b0, r3_p};
            default:   offs = {r3_p, 1'b0};
        endcase
        n_addr = base + ADDR_W'(offs);
    end

    logic [ADDR_W-1:0] r_addr;
    logic [DATA_W-1:0] r_data, r_gb;
    logic [1:0]        r_size;
    logic              r_hi, r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_pend <= 1'b0;
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
        end else begin
            if (en1) r1_v <= i_valid;
            if (en2) r2_v <= r1_v;
            if (en3) r3_v <= r2_v;
            if (r_ov && i_ready && r_pend) begin
                r_pend <= 1'b0;
            end else if (en_o) begin
                r_ov   <= r3_v && fmt_ok;
                r_pend <= r3_v && fmt_ok && (r_format == FMT_RGBA8);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ov && i_ready && r_pend) begin
            // GB half of an RGBA8 texel sits 32 bytes on in the same tile
            r_addr <= r_addr + ADDR_W'(32);
            r_data <= r_gb;
            r_last <= 1'b1;
        end else if (en_o) begin
            r_addr <= n_addr;
            r_data <= n_data;
            r_size <= n_size;
            r_hi   <= n_hi;
            r_last <= (r_format != FMT_RGBA8);
            r_gb   <= {r3_g, r3_b};
        end
    end

    assign o_valid        = r_ov;
    assign o_byte_address = r_addr;
    assign o_write_data   = r_data;
    assign o_write_size   = r_size;
    assign o_high_nibble  = r_hi;
    assign o_last_write   = r_last;

`ifndef NO_ASSERTIONS
    a_pend_first_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_ov && !o_last_write && o_write_size == SZ_HALFWORD))
        else $error("pending second half without a first RGBA8 write on show");

    a_second_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && !o_last_write) |=>
            (o_valid && o_last_write
             && o_byte_address == $past(o_byte_address) + ADDR_W'(32)))
        else $error("RGBA8 second write missing or misplaced");

    a_nibble_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_write_size != SZ_NIBBLE) |-> !o_high_nibble)
        else $error("high nibble flag on a byte or halfword write");

    a_size_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_write_size == SZ_NIBBLE || o_write_size == SZ_BYTE
                     || o_write_size == SZ_HALFWORD))
        else $error("undefined write size");
`endif

endmodule
